FILE: rtl/core/tsn_pkg.sv
// Shared widths and constants for the tangent-space normal transform pipeline.
`timescale 1ns / 1ps
`default_nettype none
package tsn_pkg;

    // Component format of the ports
    localparam int COMPONENT_BITS = 16;
    localparam int FRACTION_BITS  = 14;
    localparam int CB_IDX_W       = $clog2(COMPONENT_BITS);

    // Prescale: largest magnitude brought into [2^14, 2^15)
    localparam int PRE_TOP = 14;
    localparam int PRE_W   = PRE_TOP + 2;
    localparam int PROD_W  = 2 * PRE_W;

    // Unit-vector pipeline
    localparam int UNIT_TOP  = 29;
    localparam int UNIT_K    = 30;
    localparam int UQ_W      = UNIT_K + 2;
    localparam int UIN_W     = UQ_W + PRE_W;
    localparam int UIN_IDX_W = $clog2(UIN_W);
    localparam int SQ_W      = 2 * (UNIT_TOP + 1);
    localparam int SUM_W     = SQ_W + 2;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int QUO_W     = UNIT_K + 1;
    localparam int DIVD_W    = UNIT_TOP + 1 + UNIT_K + 1;
    localparam int DIV_R_W   = ROOT_W + 1;
    localparam int UNIT_LAT  = 3 + ROOT_W + 1 + QUO_W + 1;

    // Output clamp
    localparam longint RES_HI = (64'sd1 <<< (COMPONENT_BITS - 1)) - 64'sd1;

endpackage
`default_nettype wire

FILE: rtl/core/tsn_unit3.sv
// Pipelined unit-vector unit: scale, sum of squares, square root and rounded divide.
`timescale 1ns / 1ps
`default_nettype none
module tsn_unit3 (
    input  logic                              aclk,
    input  logic                              en,
    input  logic                              frac_mode,
    input  logic signed [tsn_pkg::UIN_W-1:0]  vec_in [3],
    output logic signed [tsn_pkg::UQ_W-1:0]   q_out [3],
    output logic                              zero_out
);
    import tsn_pkg::*;

    typedef struct packed {
        logic                      zero;
        logic [2:0]                neg;
        logic [2:0][UNIT_TOP:0]    mag;
    } uside_t;

    typedef struct packed {
        logic       zero;
        logic [2:0] neg;
    } dside_t;

    // Scale so the largest magnitude lies in [2^29, 2^30)
    logic [UIN_W-1:0]          s1_abs [3];
    logic [UIN_W-1:0]          s1_or;
    logic [UIN_IDX_W-1:0]      s1_msb;
    logic [UIN_W+UNIT_TOP-1:0] s1_wide;
    uside_t                    s1_next;
    uside_t                    s1_reg;

    always_comb begin
        s1_or = '0;
        for (int c = 0; c < 3; c++) begin
            s1_abs[c] = vec_in[c][UIN_W-1] ? UIN_W'(-vec_in[c]) : UIN_W'(vec_in[c]);
            s1_or     = s1_or | s1_abs[c];
        end
        s1_msb = '0;
        for (int i = 0; i < UIN_W; i++) begin
            if (s1_or[i]) s1_msb = UIN_IDX_W'(i);
        end
        s1_next.zero = (s1_or == '0);
        s1_wide      = '0;
        for (int c = 0; c < 3; c++) begin
            s1_next.neg[c] = vec_in[c][UIN_W-1];
            s1_wide = (UIN_W + UNIT_TOP)'(s1_abs[c]);
            if (s1_msb >= UNIT_TOP) begin
                s1_wide = s1_wide >> (s1_msb - UNIT_TOP);
            end else begin
                s1_wide = s1_wide << (UNIT_TOP - s1_msb);
            end
            s1_next.mag[c] = s1_wide[UNIT_TOP:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) s1_reg <= s1_next;
    end

    // Squares, then their sum
    logic [SQ_W-1:0]  sq_reg [3];
    uside_t           s2_reg;
    logic [SUM_W-1:0] sum_reg;
    uside_t           s3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                sq_reg[c] <= SQ_W'(s1_reg.mag[c]) * SQ_W'(s1_reg.mag[c]);
            end
            s2_reg  <= s1_reg;
            sum_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            s3_reg  <= s2_reg;
        end
    end

    // Square root, one result bit per stage
    logic [REM_W-1:0]  sr_rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] sr_root_reg [ROOT_W];
    logic [SUM_W-1:0]  sr_sum_reg  [ROOT_W];
    uside_t            sr_side_reg [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        localparam int BIT = ROOT_W - 1 - j;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SUM_W-1:0]  sum_in;
        uside_t            side_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;

        if (j == 0) begin : g_head
            assign rem_in  = '0;
            assign root_in = '0;
            assign sum_in  = sum_reg;
            assign side_in = s3_reg;
        end else begin : g_body
            assign rem_in  = sr_rem_reg[j-1];
            assign root_in = sr_root_reg[j-1];
            assign sum_in  = sr_sum_reg[j-1];
            assign side_in = sr_side_reg[j-1];
        end

        assign rem_sh = {rem_in[REM_W-3:0], sum_in[2*BIT+1 -: 2]};
        assign trial  = REM_W'({root_in, 2'b01});

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_sh >= trial) begin
                    sr_rem_reg[j]  <= rem_sh - trial;
                    sr_root_reg[j] <= {root_in[ROOT_W-2:0], 1'b1};
                end else begin
                    sr_rem_reg[j]  <= rem_sh;
                    sr_root_reg[j] <= {root_in[ROOT_W-2:0], 1'b0};
                end
                sr_sum_reg[j]  <= sum_in;
                sr_side_reg[j] <= side_in;
            end
        end
    end

    // Dividend with half-length rounding term
    logic [DIVD_W-1:0] dvd_reg [3];
    logic [ROOT_W-1:0] len_reg;
    dside_t            dp_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                dvd_reg[c] <= (DIVD_W'(sr_side_reg[ROOT_W-1].mag[c])
                               << (frac_mode ? FRACTION_BITS : UNIT_K))
                              + DIVD_W'(sr_root_reg[ROOT_W-1] >> 1);
            end
            len_reg          <= sr_root_reg[ROOT_W-1];
            dp_side_reg.zero <= sr_side_reg[ROOT_W-1].zero;
            dp_side_reg.neg  <= sr_side_reg[ROOT_W-1].neg;
        end
    end

    // Restoring divide, one quotient bit per stage on all three lanes
    logic [DIV_R_W-1:0] dv_rem_reg  [QUO_W][3];
    logic [DIVD_W-1:0]  dv_dvd_reg  [QUO_W][3];
    logic [QUO_W-1:0]   dv_quo_reg  [QUO_W][3];
    logic [ROOT_W-1:0]  dv_len_reg  [QUO_W];
    dside_t             dv_side_reg [QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        localparam int BIT = QUO_W - 1 - j;
        logic [DIV_R_W-1:0] rem_in [3];
        logic [DIVD_W-1:0]  dvd_in [3];
        logic [QUO_W-1:0]   quo_in [3];
        logic [ROOT_W-1:0]  len_in;
        dside_t             side_in;
        logic [DIV_R_W-1:0] rs     [3];

        if (j == 0) begin : g_head
            for (genvar c = 0; c < 3; c++) begin : g_lane
                assign rem_in[c] = DIV_R_W'(dvd_reg[c][DIVD_W-1:QUO_W]);
                assign dvd_in[c] = dvd_reg[c];
                assign quo_in[c] = '0;
            end
            assign len_in  = len_reg;
            assign side_in = dp_side_reg;
        end else begin : g_body
            for (genvar c = 0; c < 3; c++) begin : g_lane
                assign rem_in[c] = dv_rem_reg[j-1][c];
                assign dvd_in[c] = dv_dvd_reg[j-1][c];
                assign quo_in[c] = dv_quo_reg[j-1][c];
            end
            assign len_in  = dv_len_reg[j-1];
            assign side_in = dv_side_reg[j-1];
        end

        always_comb begin
            for (int c = 0; c < 3; c++) begin
                rs[c] = {rem_in[c][DIV_R_W-2:0], dvd_in[c][BIT]};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int c = 0; c < 3; c++) begin
                    if (rs[c] >= DIV_R_W'(len_in)) begin
                        dv_rem_reg[j][c] <= rs[c] - DIV_R_W'(len_in);
                        dv_quo_reg[j][c] <= {quo_in[c][QUO_W-2:0], 1'b1};
                    end else begin
                        dv_rem_reg[j][c] <= rs[c];
                        dv_quo_reg[j][c] <= {quo_in[c][QUO_W-2:0], 1'b0};
                    end
                    dv_dvd_reg[j][c] <= dvd_in[c];
                end
                dv_len_reg[j]  <= len_in;
                dv_side_reg[j] <= side_in;
            end
        end
    end

    // Restore signs
    logic signed [UQ_W-1:0] q_reg [3];
    logic                   zero_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                q_reg[c] <= dv_side_reg[QUO_W-1].neg[c]
                            ? -UQ_W'(dv_quo_reg[QUO_W-1][c])
                            :  UQ_W'(dv_quo_reg[QUO_W-1][c]);
            end
            zero_reg <= dv_side_reg[QUO_W-1].zero;
        end
    end

    assign q_out    = q_reg;
    assign zero_out = zero_reg;

endmodule
`default_nettype wire

FILE: rtl/core/tangent_space_normal_transform_unit.sv
// Top level of the tangent-space normal transform pipeline.
//
// Usage: one vertex per transfer on the s_ channel (tangent, handedness, normal and
// baked normal, signed fixed point); one result per transfer on the m_ channel (the
// baked normal expressed in the tangent frame, normalised, plus a degenerate flag).
// Results leave in input order, one for every vertex.
// Path from input transfer to result valid: prescale and cross-product stages, two
// unit-vector passes (31-stage square root and 31-stage divider each), the dot-product
// stages and 1 output register.
// Throughput: one vertex per cycle while the output is not stalled, set by the fully
// pipelined square root and divider stages; every stage holds its own item.
// Reset: aresetn (synchronous, active low) clears all valid bits; the block accepts a
// vertex in the first cycle after reset.
// Stall: when m_ready is low with a result waiting, the whole pipeline holds and
// s_ready drops; nothing is lost or repeated. Empty stages do not hold up the flow
// while the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module tangent_space_normal_transform_unit (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [tsn_pkg::COMPONENT_BITS-1:0] s_tangent_x,
    input  logic signed [tsn_pkg::COMPONENT_BITS-1:0] s_tangent_y,
    input  logic signed [tsn_pkg::COMPONENT_BITS-1:0] s_tangent_z,
    input  logic signed [1:0]                         s_handedness,
    input  logic signed [tsn_pkg::COMPONENT_BITS-1:0] s_normal_x,
    input  logic signed [tsn_pkg::COMPONENT_BITS-1:0] s_normal_y,
    input  logic signed [tsn_pkg::COMPONENT_BITS-1:0] s_normal_z,
    input  logic signed [tsn_pkg::COMPONENT_BITS-1:0] s_baked_x,
    input  logic signed [tsn_pkg::COMPONENT_BITS-1:0] s_baked_y,
    input  logic signed [tsn_pkg::COMPONENT_BITS-1:0] s_baked_z,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [tsn_pkg::COMPONENT_BITS-1:0] m_result_x,
    output logic signed [tsn_pkg::COMPONENT_BITS-1:0] m_result_y,
    output logic signed [tsn_pkg::COMPONENT_BITS-1:0] m_result_z,
    output logic                                    m_degenerate
);
    import tsn_pkg::*;

    localparam int CB = COMPONENT_BITS;

    // Global advance: the pipeline moves whenever the output register is free
    logic adv;
    logic out_valid_reg;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    // Prescale tangent, normal and baked normal (vector 0, 1, 2)
    logic signed [CB-1:0]    in_vec   [3][3];
    logic signed [PRE_W-1:0] pre_next [3][3];
    logic [2:0]              nz_next;
    logic [CB-1:0]           pre_abs  [3];
    logic [CB-1:0]           pre_or;
    logic [CB_IDX_W-1:0]     pre_msb;
    logic [CB+PRE_TOP-1:0]   pre_wide;

    assign in_vec[0][0] = s_tangent_x;
    assign in_vec[0][1] = s_tangent_y;
    assign in_vec[0][2] = s_tangent_z;
    assign in_vec[1][0] = s_normal_x;
    assign in_vec[1][1] = s_normal_y;
    assign in_vec[1][2] = s_normal_z;
    assign in_vec[2][0] = s_baked_x;
    assign in_vec[2][1] = s_baked_y;
    assign in_vec[2][2] = s_baked_z;

    always_comb begin
        pre_abs  = '{default: '0};
        pre_or   = '0;
        pre_msb  = '0;
        pre_wide = '0;
        for (int v = 0; v < 3; v++) begin
            pre_or = '0;
            for (int c = 0; c < 3; c++) begin
                pre_abs[c] = in_vec[v][c][CB-1] ? CB'(-in_vec[v][c]) : CB'(in_vec[v][c]);
                pre_or     = pre_or | pre_abs[c];
            end
            pre_msb = '0;
            for (int i = 0; i < CB; i++) begin
                if (pre_or[i]) pre_msb = CB_IDX_W'(i);
            end
            nz_next[v] = (pre_or != '0);
            for (int c = 0; c < 3; c++) begin
                pre_wide = (CB + PRE_TOP)'(pre_abs[c]);
                if (pre_msb >= PRE_TOP) begin
                    pre_wide = pre_wide >> (pre_msb - PRE_TOP);
                end else begin
                    pre_wide = pre_wide << (PRE_TOP - pre_msb);
                end
                pre_next[v][c] = in_vec[v][c][CB-1]
                                 ? -PRE_W'(pre_wide[PRE_TOP:0])
                                 :  PRE_W'(pre_wide[PRE_TOP:0]);
            end
        end
    end

    logic signed [PRE_W-1:0] p1_vec_reg [3][3];
    logic                    p1_ok_reg;
    logic                    p1_hneg_reg;
    logic                    p1_valid_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_vec_reg  <= pre_next;
            p1_ok_reg   <= (&nz_next) && (s_handedness != 2'sd0);
            p1_hneg_reg <= s_handedness[1];
        end
    end

    // Cross product terms
    logic signed [PROD_W-1:0] p2_prod_reg [6];
    logic signed [PRE_W-1:0]  p2_vec_reg  [3][3];
    logic                     p2_ok_reg;
    logic                     p2_hneg_reg;
    logic                     p2_valid_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_prod_reg[0] <= p1_vec_reg[1][1] * p1_vec_reg[0][2];
            p2_prod_reg[1] <= p1_vec_reg[1][2] * p1_vec_reg[0][1];
            p2_prod_reg[2] <= p1_vec_reg[1][2] * p1_vec_reg[0][0];
            p2_prod_reg[3] <= p1_vec_reg[1][0] * p1_vec_reg[0][2];
            p2_prod_reg[4] <= p1_vec_reg[1][0] * p1_vec_reg[0][1];
            p2_prod_reg[5] <= p1_vec_reg[1][1] * p1_vec_reg[0][0];
            p2_vec_reg     <= p1_vec_reg;
            p2_ok_reg      <= p1_ok_reg;
            p2_hneg_reg    <= p1_hneg_reg;
        end
    end

    // Bitangent with handedness applied
    logic signed [PROD_W-1:0] bt_next  [3];
    logic signed [PROD_W-1:0] p3_bt_reg [3];
    logic signed [PRE_W-1:0]  p3_vec_reg [3][3];
    logic                     p3_ok_reg;
    logic                     p3_valid_reg;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            bt_next[c] = p2_prod_reg[2*c] - p2_prod_reg[2*c+1];
            if (p2_hneg_reg) bt_next[c] = -bt_next[c];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p3_bt_reg  <= bt_next;
            p3_vec_reg <= p2_vec_reg;
            p3_ok_reg  <= p2_ok_reg;
        end
    end

    // Unit tangent, bitangent and normal
    logic signed [UIN_W-1:0] ut_in [3];
    logic signed [UIN_W-1:0] ub_in [3];
    logic signed [UIN_W-1:0] un_in [3];
    logic signed [UQ_W-1:0]  ut_q  [3];
    logic signed [UQ_W-1:0]  ub_q  [3];
    logic signed [UQ_W-1:0]  un_q  [3];
    logic                    ut_zero;
    logic                    ub_zero;
    logic                    un_zero;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            ut_in[c] = UIN_W'(p3_vec_reg[0][c]);
            ub_in[c] = UIN_W'(p3_bt_reg[c]);
            un_in[c] = UIN_W'(p3_vec_reg[1][c]);
        end
    end

    tsn_unit3 u_unit_t (
        .aclk      (aclk),
        .en        (adv),
        .frac_mode (1'b0),
        .vec_in    (ut_in),
        .q_out     (ut_q),
        .zero_out  (ut_zero)
    );

    tsn_unit3 u_unit_b (
        .aclk      (aclk),
        .en        (adv),
        .frac_mode (1'b0),
        .vec_in    (ub_in),
        .q_out     (ub_q),
        .zero_out  (ub_zero)
    );

    tsn_unit3 u_unit_n (
        .aclk      (aclk),
        .en        (adv),
        .frac_mode (1'b0),
        .vec_in    (un_in),
        .q_out     (un_q),
        .zero_out  (un_zero)
    );

    // Baked normal and status alongside the first unit pass
    logic signed [PRE_W-1:0] d1_b_reg  [UNIT_LAT][3];
    logic                    d1_ok_reg [UNIT_LAT];

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_b_reg[0]  <= p3_vec_reg[2];
            d1_ok_reg[0] <= p3_ok_reg;
            for (int i = 1; i < UNIT_LAT; i++) begin
                d1_b_reg[i]  <= d1_b_reg[i-1];
                d1_ok_reg[i] <= d1_ok_reg[i-1];
            end
        end
    end

    // Projections of the baked normal: products, then sums
    logic signed [UIN_W-1:0] p4_prod_reg [3][3];
    logic                    p4_ok_reg;
    logic                    p4_valid_reg;
    logic signed [UIN_W-1:0] p5_r_reg [3];
    logic                    p5_ok_reg;
    logic                    p5_valid_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                p4_prod_reg[0][c] <= ut_q[c] * d1_b_reg[UNIT_LAT-1][c];
                p4_prod_reg[1][c] <= ub_q[c] * d1_b_reg[UNIT_LAT-1][c];
                p4_prod_reg[2][c] <= un_q[c] * d1_b_reg[UNIT_LAT-1][c];
            end
            p4_ok_reg <= d1_ok_reg[UNIT_LAT-1] && !ut_zero && !ub_zero && !un_zero;
            for (int k = 0; k < 3; k++) begin
                p5_r_reg[k] <= p4_prod_reg[k][0] + p4_prod_reg[k][1] + p4_prod_reg[k][2];
            end
            p5_ok_reg <= p4_ok_reg;
        end
    end

    // Normalise the projection to the output format
    logic signed [UQ_W-1:0] ur_q [3];
    logic                   ur_zero;
    logic                   d2_ok_reg [UNIT_LAT];

    tsn_unit3 u_unit_r (
        .aclk      (aclk),
        .en        (adv),
        .frac_mode (1'b1),
        .vec_in    (p5_r_reg),
        .q_out     (ur_q),
        .zero_out  (ur_zero)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            d2_ok_reg[0] <= p5_ok_reg;
            for (int i = 1; i < UNIT_LAT; i++) begin
                d2_ok_reg[i] <= d2_ok_reg[i-1];
            end
        end
    end

    // Valid bits for every stage
    logic [UNIT_LAT-1:0] d1_valid_reg;
    logic [UNIT_LAT-1:0] d2_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            d1_valid_reg  <= '0;
            p4_valid_reg  <= 1'b0;
            p5_valid_reg  <= 1'b0;
            d2_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg  <= s_valid;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= p2_valid_reg;
            d1_valid_reg  <= {d1_valid_reg[UNIT_LAT-2:0], p3_valid_reg};
            p4_valid_reg  <= d1_valid_reg[UNIT_LAT-1];
            p5_valid_reg  <= p4_valid_reg;
            d2_valid_reg  <= {d2_valid_reg[UNIT_LAT-2:0], p5_valid_reg};
            out_valid_reg <= d2_valid_reg[UNIT_LAT-1];
        end
    end

    // Clamp, zero on degenerate input, output register
    logic                 degen_next;
    logic signed [CB-1:0] res_next [3];
    logic signed [CB-1:0] res_reg  [3];
    logic                 degen_reg;

    always_comb begin
        degen_next = !d2_ok_reg[UNIT_LAT-1] || ur_zero;
        for (int c = 0; c < 3; c++) begin
            if (degen_next) begin
                res_next[c] = '0;
            end else if (longint'(ur_q[c]) > RES_HI) begin
                res_next[c] = CB'(RES_HI);
            end else begin
                res_next[c] = CB'(ur_q[c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg   <= res_next;
            degen_reg <= degen_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_result_x   = res_reg[0];
    assign m_result_y   = res_reg[1];
    assign m_result_z   = res_reg[2];
    assign m_degenerate = degen_reg;

endmodule
`default_nettype wire
